>>> rtl/frame_normalize_and_stats_unit_macros.svh
// assertion macros for the frame normalize and stats unit
// used by the top level, no other dependencies
`ifndef FRAME_NORMALIZE_AND_STATS_UNIT_MACROS_SVH
`define FRAME_NORMALIZE_AND_STATS_UNIT_MACROS_SVH

// same-cycle implication
`define FNAS_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FNAS_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/fnas_pkg.sv
// types and constants of the frame normalize and stats unit
// no dependencies
package fnas_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int CFG_IDX_W = 3;
    localparam int SIDE_W    = 9;
    localparam int FRAMES_W  = 16;
    localparam int SQRT_STEPS = 16;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_SIDE   = 3'd0,
        CFG_NORM_ENABLE  = 3'd1,
        CFG_TARGET_MEAN  = 3'd2,
        CFG_TARGET_SPRD  = 3'd3,
        CFG_CLIP_RANGE   = 3'd4,
        CFG_INVERT       = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_SQ,
        ST_DIV,
        ST_ISQRT,
        ST_RD_MUL,
        ST_RD_POST,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        JOB_CENTER,
        JOB_VAR,
        JOB_SCALE,
        JOB_FAVG,
        JOB_SAVG
    } div_job_t;

    typedef struct packed {
        sample_t               pixel;
        logic                  last_of_frame;
        sample_t               frame_minimum;
        sample_t               frame_maximum;
        sample_t               frame_average;
        sample_t               stack_minimum;
        sample_t               stack_maximum;
        sample_t               stack_average;
        logic [FRAMES_W-1:0]   frames_written;
    } result_t;

    localparam logic [SIDE_W-1:0]   SIDE_RST   = 9'd256;
    localparam sample_t             SPREAD_RST = 16'sd256;
    localparam sample_t             CLIP_RST   = 16'sd909;
    localparam logic [FRAMES_W-1:0] FRAMES_MAX = 16'hFFFF;

endpackage

>>> rtl/fnas_ifs.sv
// channel interfaces: input items, results and configuration writes
// depends on fnas_pkg
interface fnas_item_if;
    import fnas_pkg::*;
    logic    valid;
    logic    ready;
    logic    action;
    sample_t sample;
    modport source (output valid, output action, output sample, input ready);
    modport sink (input valid, input action, input sample, output ready);
endinterface

interface fnas_result_if;
    import fnas_pkg::*;
    logic                valid;
    logic                ready;
    sample_t             pixel;
    logic                last_of_frame;
    sample_t             frame_minimum;
    sample_t             frame_maximum;
    sample_t             frame_average;
    sample_t             stack_minimum;
    sample_t             stack_maximum;
    sample_t             stack_average;
    logic [FRAMES_W-1:0] frames_written;
    modport source (output valid, output pixel, output last_of_frame, output frame_minimum,
                    output frame_maximum, output frame_average, output stack_minimum,
                    output stack_maximum, output stack_average, output frames_written,
                    input ready);
    modport sink (input valid, input pixel, input last_of_frame, input frame_minimum,
                  input frame_maximum, input frame_average, input stack_minimum,
                  input stack_maximum, input stack_average, input frames_written,
                  output ready);
endinterface

interface fnas_cfg_if;
    import fnas_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [SAMPLE_W-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/fnas_ram.sv
// generic single-port synchronous ram with registered read
// no dependencies
module fnas_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                      wdata,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            rdata <= mem[addr];
        end
    end
endmodule

>>> rtl/frame_normalize_and_stats_unit.sv
// Samples load at one per cycle. The transfer that loads the last sample of a frame starts
// the statistics: a sum pass and a square pass over the frame store, the centring and
// variance divisions and, unless the root is zero, a scale division in the shared bit-serial
// divider, and a square root, during which no item is taken. A read-out passes through the
// multiply, post-processing and output states, waiting in the output state while the last
// result is not taken, and the last read-out of a frame adds two divider runs.
// The store needs no clearing after reset.
// depends on fnas_pkg, fnas_ifs, fnas_ram and the macros header
module frame_normalize_and_stats_unit #(
    parameter int MAX_SIDE = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    fnas_item_if.sink      item,
    fnas_result_if.source  result,
    fnas_cfg_if.sink       cfg
);
    import fnas_pkg::*;
    `include "frame_normalize_and_stats_unit_macros.svh"

    localparam int MAX_LEN = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int SUM_W   = SAMPLE_W + ADDR_W + 1;
    localparam int QACC_W  = 2 * SAMPLE_W + ADDR_W;
    localparam int DIV_N   = QACC_W + 1;
    localparam int DIV_D   = (CNT_W > SAMPLE_W) ? CNT_W : SAMPLE_W;
    localparam int DIV_CW  = $clog2(DIV_N + 1);
    localparam int PROD_W  = 3 * SAMPLE_W + 2;
    localparam int SQRT_W  = 2 * SAMPLE_W + 1;
    localparam int SQC_W   = $clog2(SQRT_STEPS + 1);

    state_t state_reg, state_next;

    logic [SIDE_W-1:0] side_reg;
    logic              norm_en_reg;
    logic              invert_reg;
    sample_t           tmean_reg;
    sample_t           tspread_reg;
    sample_t           clip_reg;

    logic [CNT_W-1:0]  load_idx_reg;
    logic [CNT_W-1:0]  readout_idx_reg;
    logic [CNT_W-1:0]  pass_idx_reg;
    logic [CNT_W-1:0]  len_reg;
    logic              frame_ready_reg;
    logic              pend1_reg;
    logic              pend2_reg;

    logic signed [SUM_W-1:0] sum_acc_reg;
    logic [2*SAMPLE_W-1:0]   sq_reg;
    logic [QACC_W-1:0]       qacc_reg;
    sample_t                 center_reg;
    logic [SAMPLE_W:0]       sa_reg;
    logic [2*SAMPLE_W-1:0]   scale_reg;

    sample_t                  x_reg;
    logic signed [PROD_W-1:0] prod_reg;
    sample_t                  px_reg;
    logic                     last_reg;
    sample_t                  run_min_reg;
    sample_t                  run_max_reg;
    logic signed [SUM_W-1:0]  run_sum_reg;
    sample_t                  favg_reg;

    sample_t                  stack_low_reg;
    sample_t                  stack_high_reg;
    sample_t                  savg_reg;
    logic signed [31:0]       stack_sum_reg;
    logic [FRAMES_W-1:0]      frames_reg;

    logic    out_valid_reg;
    result_t out_reg;

    logic [DIV_N-1:0]  div_num_reg;
    logic [DIV_D-1:0]  div_rem_reg;
    logic [DIV_D-1:0]  div_den_reg;
    logic              div_neg_reg;
    logic [DIV_CW-1:0] div_cnt_reg;
    div_job_t          div_job_reg;

    logic [SQRT_W-1:0] sq_v_reg;
    logic [SQRT_W-1:0] sq_r_reg;
    logic [SQRT_W-1:0] sq_bit_reg;
    logic [SQC_W-1:0]  sq_cnt_reg;

    logic                     item_fire;
    logic                     cfg_fire;
    logic                     out_free;
    logic [SIDE_W-1:0]        side_c;
    logic [2*SIDE_W-1:0]      len_raw;
    logic [CNT_W-1:0]         len_c;
    logic                     load_last;
    logic                     rd_last;
    logic                     pass_more;
    logic                     ram_en;
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_addr;
    logic [SAMPLE_W-1:0]      ram_rdata;
    sample_t                  ram_x;
    logic signed [SAMPLE_W:0] diff_c;
    logic signed [2*SAMPLE_W+1:0] sq_full;
    logic signed [PROD_W-1:0] prod_c;

    logic                     div_start;
    div_job_t                 div_job_in;
    logic signed [DIV_N-1:0]  div_num_in;
    logic [DIV_D-1:0]         div_den_in;
    logic [DIV_D:0]           rem_sh;
    logic [DIV_D:0]           rem_sub;
    logic                     div_ge;
    logic                     div_done;
    logic [DIV_N-1:0]         div_q;
    sample_t                  q_s;

    logic [SQRT_W-1:0]        sq_t;
    logic                     sq_ge;
    logic                     sq_done;

    logic signed [PROD_W-SAMPLE_W-1:0] v0;
    logic signed [PROD_W-SAMPLE_W:0]   v1;
    logic signed [PROD_W-SAMPLE_W:0]   clip_c;
    logic signed [PROD_W-SAMPLE_W:0]   v2;
    logic signed [SAMPLE_W+1:0]        v3;
    sample_t                           norm_px;
    sample_t                           px_c;

    logic [FRAMES_W-1:0]      frames_new;
    logic signed [31:0]       stack_sum_new;

    assign item_fire = item.valid && item.ready;
    assign cfg_fire  = cfg.valid && cfg.ready;
    assign out_free  = !out_valid_reg || result.ready;
    assign item.ready = (state_reg == ST_IDLE);
    assign cfg.ready  = 1'b1;

    // frame length from the side register, clamped to the store
    always_comb
    begin
        if (side_reg == '0)
        begin
            side_c = SIDE_W'(1);
        end
        else if (int'(side_reg) > MAX_SIDE)
        begin
            side_c = SIDE_W'(MAX_SIDE);
        end
        else
        begin
            side_c = side_reg;
        end
    end

    assign len_raw   = (2*SIDE_W)'(side_c) * (2*SIDE_W)'(side_c);
    assign len_c     = CNT_W'(len_raw);
    assign load_last = ((CNT_W+1)'(load_idx_reg) + 1'b1) >= (CNT_W+1)'(len_c);
    assign rd_last   = ((CNT_W+1)'(readout_idx_reg) + 1'b1) >= (CNT_W+1)'(len_c);
    assign pass_more = pass_idx_reg < len_reg;

    assign ram_x   = sample_t'(ram_rdata);
    assign diff_c  = (SAMPLE_W+1)'(ram_x) - (SAMPLE_W+1)'(center_reg);
    assign sq_full = (2*SAMPLE_W+2)'(diff_c) * (2*SAMPLE_W+2)'(diff_c);
    assign prod_c  = PROD_W'(diff_c) * PROD_W'($signed({1'b0, scale_reg}));

    // bit-serial divider, floor division of a signed numerator
    assign rem_sh   = {div_rem_reg, div_num_reg[DIV_N-1]};
    assign rem_sub  = rem_sh - {1'b0, div_den_reg};
    assign div_ge   = rem_sh >= {1'b0, div_den_reg};
    assign div_done = (div_cnt_reg == DIV_CW'(DIV_N));
    assign div_q    = div_neg_reg ? ~div_num_reg : div_num_reg;
    assign q_s      = sample_t'(div_q[SAMPLE_W-1:0]);

    assign sq_t    = sq_r_reg + sq_bit_reg;
    assign sq_ge   = sq_v_reg >= sq_t;
    assign sq_done = (sq_cnt_reg == SQC_W'(SQRT_STEPS));

    // normalize, invert, clip, offset and saturate, or pass the raw sample when normalization is off
    always_comb
    begin
        v0 = prod_reg[PROD_W-1:SAMPLE_W] + (PROD_W-SAMPLE_W)'(prod_reg[SAMPLE_W-1]);
        v1 = invert_reg ? -(PROD_W-SAMPLE_W+1)'(v0) : (PROD_W-SAMPLE_W+1)'(v0);
        clip_c = clip_reg[SAMPLE_W-1] ? -(PROD_W-SAMPLE_W+1)'(clip_reg)
                                      : (PROD_W-SAMPLE_W+1)'(clip_reg);
        if (v1 < -clip_c)
        begin
            v2 = -clip_c;
        end
        else if (v1 > clip_c)
        begin
            v2 = clip_c;
        end
        else
        begin
            v2 = v1;
        end
        v3 = (SAMPLE_W+2)'(v2) + (SAMPLE_W+2)'(tmean_reg);
        if (v3 > (SAMPLE_W+2)'(sample_t'({1'b0, {(SAMPLE_W-1){1'b1}}})))
        begin
            norm_px = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        else if (v3 < (SAMPLE_W+2)'(sample_t'({1'b1, {(SAMPLE_W-1){1'b0}}})))
        begin
            norm_px = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end
        else
        begin
            norm_px = v3[SAMPLE_W-1:0];
        end
        px_c = norm_en_reg ? norm_px : x_reg;
    end

    // stack bookkeeping at the end of a frame
    always_comb
    begin
        frames_new = (frames_reg == FRAMES_MAX) ? frames_reg : frames_reg + 1'b1;
        if (frames_reg == '0)
        begin
            stack_sum_new = 32'(q_s);
        end
        else if (frames_reg != FRAMES_MAX)
        begin
            stack_sum_new = stack_sum_reg + 32'(q_s);
        end
        else
        begin
            stack_sum_new = stack_sum_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ram_en     = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = '0;
        div_start  = 1'b0;
        div_job_in = JOB_CENTER;
        div_num_in = '0;
        div_den_in = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_fire)
                begin
                    if (!item.action)
                    begin
                        if (!frame_ready_reg)
                        begin
                            ram_en   = 1'b1;
                            ram_we   = 1'b1;
                            ram_addr = load_idx_reg[ADDR_W-1:0];
                            if (load_last)
                            begin
                                state_next = ST_SUM;
                            end
                        end
                    end
                    else if (frame_ready_reg)
                    begin
                        ram_en     = 1'b1;
                        ram_addr   = readout_idx_reg[ADDR_W-1:0];
                        state_next = ST_RD_MUL;
                    end
                end
            end
            ST_SUM:
            begin
                ram_en   = pass_more;
                ram_addr = pass_idx_reg[ADDR_W-1:0];
                if (!pass_more && !pend1_reg)
                begin
                    div_start  = 1'b1;
                    div_job_in = JOB_CENTER;
                    div_num_in = DIV_N'(sum_acc_reg) + DIV_N'(len_reg >> 1);
                    div_den_in = DIV_D'(len_reg);
                    state_next = ST_DIV;
                end
            end
            ST_SQ:
            begin
                ram_en   = pass_more;
                ram_addr = pass_idx_reg[ADDR_W-1:0];
                if (!pass_more && !pend1_reg && !pend2_reg)
                begin
                    div_start  = 1'b1;
                    div_job_in = JOB_VAR;
                    div_num_in = DIV_N'(qacc_reg);
                    div_den_in = DIV_D'(len_reg);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    unique case (div_job_reg)
                        JOB_CENTER: state_next = ST_SQ;
                        JOB_VAR:    state_next = ST_ISQRT;
                        JOB_SCALE:  state_next = ST_IDLE;
                        JOB_FAVG:
                        begin
                            div_start  = 1'b1;
                            div_job_in = JOB_SAVG;
                            div_num_in = DIV_N'(stack_sum_new) + DIV_N'(frames_new >> 1);
                            div_den_in = DIV_D'(frames_new);
                        end
                        JOB_SAVG:   state_next = ST_OUT;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ISQRT:
            begin
                if (sq_done)
                begin
                    if (sq_r_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        div_job_in = JOB_SCALE;
                        div_num_in = DIV_N'({sa_reg, {SAMPLE_W{1'b0}}})
                                   + DIV_N'(sq_r_reg >> 1);
                        div_den_in = DIV_D'(sq_r_reg);
                        state_next = ST_DIV;
                    end
                end
            end
            ST_RD_MUL:
            begin
                state_next = ST_RD_POST;
            end
            ST_RD_POST:
            begin
                if (rd_last)
                begin
                    div_start  = 1'b1;
                    div_job_in = JOB_FAVG;
                    div_num_in = DIV_N'(run_sum_reg) + DIV_N'(len_c >> 1);
                    if (readout_idx_reg == '0)
                    begin
                        div_num_in = DIV_N'(px_c) + DIV_N'(len_c >> 1);
                    end
                    else
                    begin
                        div_num_in = DIV_N'(run_sum_reg) + DIV_N'(px_c) + DIV_N'(len_c >> 1);
                    end
                    div_den_in = DIV_D'(len_c);
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    fnas_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_LEN)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (item.sample),
        .rdata (ram_rdata)
    );

    // divider and square root working registers
    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            div_neg_reg <= div_num_in[DIV_N-1];
            div_num_reg <= div_num_in[DIV_N-1] ? ~div_num_in : div_num_in;
            div_rem_reg <= '0;
            div_den_reg <= div_den_in;
            div_cnt_reg <= '0;
            div_job_reg <= div_job_in;
        end
        else if (state_reg == ST_DIV && !div_done)
        begin
            div_rem_reg <= div_ge ? rem_sub[DIV_D-1:0] : rem_sh[DIV_D-1:0];
            div_num_reg <= {div_num_reg[DIV_N-2:0], div_ge};
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end

        if (state_reg == ST_DIV && div_done && div_job_reg == JOB_VAR)
        begin
            sq_v_reg   <= SQRT_W'(div_q[2*SAMPLE_W-1:0]);
            sq_r_reg   <= '0;
            sq_bit_reg <= SQRT_W'(1) << (2*SAMPLE_W-2);
            sq_cnt_reg <= '0;
        end
        else if (state_reg == ST_ISQRT && !sq_done)
        begin
            if (sq_ge)
            begin
                sq_v_reg <= sq_v_reg - sq_t;
                sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
            end
            else
            begin
                sq_r_reg <= sq_r_reg >> 1;
            end
            sq_bit_reg <= sq_bit_reg >> 2;
            sq_cnt_reg <= sq_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg        <= SIDE_RST;
            norm_en_reg     <= 1'b1;
            invert_reg      <= 1'b0;
            tmean_reg       <= '0;
            tspread_reg     <= SPREAD_RST;
            clip_reg        <= CLIP_RST;
            load_idx_reg    <= '0;
            readout_idx_reg <= '0;
            pass_idx_reg    <= '0;
            len_reg         <= '0;
            frame_ready_reg <= 1'b0;
            pend1_reg       <= 1'b0;
            pend2_reg       <= 1'b0;
            sum_acc_reg     <= '0;
            sq_reg          <= '0;
            qacc_reg        <= '0;
            center_reg      <= '0;
            sa_reg          <= '0;
            scale_reg       <= '0;
            x_reg           <= '0;
            prod_reg        <= '0;
            px_reg          <= '0;
            last_reg        <= 1'b0;
            run_min_reg     <= '0;
            run_max_reg     <= '0;
            run_sum_reg     <= '0;
            favg_reg        <= '0;
            stack_low_reg   <= '0;
            stack_high_reg  <= '0;
            savg_reg        <= '0;
            stack_sum_reg   <= '0;
            frames_reg      <= '0;
            out_valid_reg   <= 1'b0;
            out_reg         <= '0;
        end
        else
        begin
            if (cfg_fire)
            begin
                unique case (cfg_idx_t'(cfg.index))
                    CFG_FRAME_SIDE:  side_reg    <= cfg.data[SIDE_W-1:0];
                    CFG_NORM_ENABLE: norm_en_reg <= cfg.data[0];
                    CFG_TARGET_MEAN: tmean_reg   <= sample_t'(cfg.data);
                    CFG_TARGET_SPRD: tspread_reg <= sample_t'(cfg.data);
                    CFG_CLIP_RANGE:  clip_reg    <= sample_t'(cfg.data);
                    CFG_INVERT:      invert_reg  <= cfg.data[0];
                    default:         ;
                endcase
            end

            if (state_reg == ST_OUT && out_free)
            begin
                out_valid_reg          <= 1'b1;
                out_reg.pixel          <= px_reg;
                out_reg.last_of_frame  <= last_reg;
                out_reg.frame_minimum  <= last_reg ? run_min_reg : '0;
                out_reg.frame_maximum  <= last_reg ? run_max_reg : '0;
                out_reg.frame_average  <= last_reg ? favg_reg : '0;
                out_reg.stack_minimum  <= stack_low_reg;
                out_reg.stack_maximum  <= stack_high_reg;
                out_reg.stack_average  <= savg_reg;
                out_reg.frames_written <= frames_reg;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (item_fire && !item.action && !frame_ready_reg)
                    begin
                        load_idx_reg <= load_idx_reg + 1'b1;
                        if (load_last)
                        begin
                            len_reg      <= len_c;
                            sa_reg       <= tspread_reg[SAMPLE_W-1]
                                            ? -(SAMPLE_W+1)'(tspread_reg)
                                            : (SAMPLE_W+1)'(tspread_reg);
                            pass_idx_reg <= '0;
                            pend1_reg    <= 1'b0;
                            pend2_reg    <= 1'b0;
                            sum_acc_reg  <= '0;
                        end
                    end
                end
                ST_SUM:
                begin
                    pend1_reg <= pass_more;
                    if (pass_more)
                    begin
                        pass_idx_reg <= pass_idx_reg + 1'b1;
                    end
                    if (pend1_reg)
                    begin
                        sum_acc_reg <= sum_acc_reg + SUM_W'(ram_x);
                    end
                end
                ST_SQ:
                begin
                    pend1_reg <= pass_more;
                    pend2_reg <= pend1_reg;
                    if (pass_more)
                    begin
                        pass_idx_reg <= pass_idx_reg + 1'b1;
                    end
                    if (pend1_reg)
                    begin
                        sq_reg <= sq_full[2*SAMPLE_W-1:0];
                    end
                    if (pend2_reg)
                    begin
                        qacc_reg <= qacc_reg + QACC_W'(sq_reg);
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        unique case (div_job_reg)
                            JOB_CENTER:
                            begin
                                center_reg   <= q_s;
                                pass_idx_reg <= '0;
                                pend1_reg    <= 1'b0;
                                pend2_reg    <= 1'b0;
                                qacc_reg     <= '0;
                            end
                            JOB_VAR: ;
                            JOB_SCALE:
                            begin
                                scale_reg       <= div_q[2*SAMPLE_W-1:0];
                                frame_ready_reg <= 1'b1;
                                readout_idx_reg <= '0;
                            end
                            JOB_FAVG:
                            begin
                                favg_reg      <= q_s;
                                stack_sum_reg <= stack_sum_new;
                                frames_reg    <= frames_new;
                                if (frames_reg == '0)
                                begin
                                    stack_low_reg  <= run_min_reg;
                                    stack_high_reg <= run_max_reg;
                                end
                                else
                                begin
                                    if (run_min_reg < stack_low_reg)
                                    begin
                                        stack_low_reg <= run_min_reg;
                                    end
                                    if (run_max_reg > stack_high_reg)
                                    begin
                                        stack_high_reg <= run_max_reg;
                                    end
                                end
                            end
                            JOB_SAVG:
                            begin
                                savg_reg        <= q_s;
                                frame_ready_reg <= 1'b0;
                                load_idx_reg    <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_ISQRT:
                begin
                    if (sq_done && sq_r_reg == '0)
                    begin
                        scale_reg       <= '0;
                        frame_ready_reg <= 1'b1;
                        readout_idx_reg <= '0;
                    end
                end
                ST_RD_MUL:
                begin
                    x_reg    <= ram_x;
                    prod_reg <= prod_c;
                end
                ST_RD_POST:
                begin
                    px_reg   <= px_c;
                    last_reg <= rd_last;
                    if (readout_idx_reg == '0)
                    begin
                        run_min_reg <= px_c;
                        run_max_reg <= px_c;
                        run_sum_reg <= SUM_W'(px_c);
                    end
                    else
                    begin
                        if (px_c < run_min_reg)
                        begin
                            run_min_reg <= px_c;
                        end
                        if (px_c > run_max_reg)
                        begin
                            run_max_reg <= px_c;
                        end
                        run_sum_reg <= run_sum_reg + SUM_W'(px_c);
                    end
                    readout_idx_reg <= rd_last ? '0 : readout_idx_reg + 1'b1;
                end
                ST_OUT: ;
                default: ;
            endcase
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.pixel          = out_reg.pixel;
    assign result.last_of_frame  = out_reg.last_of_frame;
    assign result.frame_minimum  = out_reg.frame_minimum;
    assign result.frame_maximum  = out_reg.frame_maximum;
    assign result.frame_average  = out_reg.frame_average;
    assign result.stack_minimum  = out_reg.stack_minimum;
    assign result.stack_maximum  = out_reg.stack_maximum;
    assign result.stack_average  = out_reg.stack_average;
    assign result.frames_written = out_reg.frames_written;

    `FNAS_ASSERT_NOW(a_last_counts_frame, clk, rst_n,
        out_valid_reg && out_reg.last_of_frame, out_reg.frames_written != '0,
        "last transfer without a finished frame")
    `FNAS_ASSERT_NOW(a_readout_needs_frame, clk, rst_n,
        state_reg == ST_RD_MUL || state_reg == ST_RD_POST, frame_ready_reg,
        "read-out with no frame ready")
    `FNAS_ASSERT_NEXT(a_frame_end_clears, clk, rst_n,
        state_reg == ST_DIV && div_done && div_job_reg == JOB_SAVG,
        !frame_ready_reg && load_idx_reg == '0,
        "frame not released after last read-out")

endmodule
